// File: src/bssi_pkg.sv
`default_nettype none

package bssi_pkg;

   // width of the internal duty state; the result field carries its low 16 bits
   localparam int DUTY_BITS = 16;

   localparam logic [7:0]  UP_ANGLE_RESET   = 8'd90;
   localparam logic [7:0]  DOWN_ANGLE_RESET = 8'd0;
   localparam logic [7:0]  SLEW_STEP_RESET  = 8'd2;
   localparam logic [15:0] PULSE_MIN_RESET  = 16'd1638;
   localparam logic [15:0] PULSE_MAX_RESET  = 16'd7864;
   localparam logic [7:0]  ANGLE_LIMIT      = 8'd180;

   // duty of the reset angle with the reset pulse range, saturated to the duty width
   localparam int DUTY_TOP       = (2 ** DUTY_BITS) - 1;
   localparam int DUTY_RESET_RAW = 1638 + ((7864 - 1638) * 90) / 180;
   localparam int DUTY_RESET     = (DUTY_RESET_RAW > DUTY_TOP) ? DUTY_TOP : DUTY_RESET_RAW;

   // floor(x / 45) = (x * RECIP_45) >> RECIP_SHIFT, exact for x below 2^28 / 29
   localparam int          RECIP_SHIFT = 28;
   localparam logic [22:0] RECIP_45    = 23'd5965233;

   typedef enum logic [1:0] {
      KIND_TICK    = 2'd0,
      KIND_REQUEST = 2'd1,
      KIND_FORCE   = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      CSR_UP_ANGLE   = 3'd0,
      CSR_DOWN_ANGLE = 3'd1,
      CSR_SLEW_STEP  = 3'd2,
      CSR_PULSE_MIN  = 3'd3,
      CSR_PULSE_MAX  = 3'd4
   } csr_index_type;

   // result fields that ride along the duty pipeline
   typedef struct packed {
      logic       relay_on;
      logic [7:0] position;
      logic       target_reached;
      logic       estop_held;
      logic       estop_pressed;
      logic       estop_released;
      logic       barrier_closed;
      logic       barrier_open;
      logic       duty_update;
   } res_fields_type;

endpackage

`default_nettype wire

// File: src/barrier_servo_slew_interlock_unit.sv
`default_nettype none
// Pipeline: rsp_tvalid rises once the request transfer has passed five register stages
// (input register, duty multiply, magnitude, reciprocal multiply by 1/45, offset and clamp).
// Throughput: one item per cycle while rsp_tready allows; the angle and interlock state update
// in the accept cycle, and the duty map runs in a stalling pipeline with a valid bit per stage.
// Reset: synchronous, active high; position and target return to 90, relay off, duty to its 90 degree value.
module barrier_servo_slew_interlock_unit
   import bssi_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // configuration write channel
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_data,
   // request stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,  // [7:0] angle, [8] estop, [9] fault_present, rest 0
   input  wire logic [1:0]  req_tuser,  // [1:0] kind
   // result stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata   // [0] relay_on, [16:1] servo_duty, [24:17] position,
                                        // [25] target_reached, [26] estop_held,
                                        // [27] estop_pressed_event, [28] estop_released_event,
                                        // [29] barrier_closed_event, [30] barrier_open_event
);

   // configuration
   logic [7:0]  down_angle_ff, slew_step_ff;
   logic [15:0] pulse_min_ff, pulse_max_ff;

   // architectural state
   logic [7:0] current_pos_ff, current_pos_in;
   logic [7:0] target_pos_ff, target_pos_in;
   logic       estop_prev_ff, estop_prev_in;
   logic       done_prev_ff, done_prev_in;
   logic       relay_state_ff, relay_state_in;

   // pipeline
   logic                 v1_ff, v2_ff, v3_ff, v4_ff, out_v_ff;
   res_fields_type       f1_ff, f2_ff, f3_ff, f4_ff, out_f_ff;
   res_fields_type       f1_in;
   logic [7:0]           duty_angle_ff, duty_angle_in;
   logic signed [25:0]   prod_ff;
   logic [21:0]          mag_q4_ff;
   logic                 neg3_ff, neg4_ff;
   logic [15:0]          quot_ff;
   logic [DUTY_BITS-1:0] duty_ff;

   logic rdy1, rdy2, rdy3, rdy4, move_out, accept;

   logic [7:0] angle_in;
   logic       estop_in, fault_in;
   kind_type   kind_in;

   assign angle_in = req_tdata[7:0];
   assign estop_in = req_tdata[8];
   assign fault_in = req_tdata[9];
   assign kind_in  = kind_type'(req_tuser);

   assign move_out   = !out_v_ff || rsp_tready;
   assign rdy4       = !v4_ff || move_out;
   assign rdy3       = !v3_ff || rdy4;
   assign rdy2       = !v2_ff || rdy3;
   assign rdy1       = !v1_ff || rdy2;
   assign req_tready = rdy1;
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // ---------------- configuration writes ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         down_angle_ff <= DOWN_ANGLE_RESET;
         slew_step_ff  <= SLEW_STEP_RESET;
         pulse_min_ff  <= PULSE_MIN_RESET;
         pulse_max_ff  <= PULSE_MAX_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_UP_ANGLE:   ; // raised angle write is ignored; the reset position is fixed
            CSR_DOWN_ANGLE: down_angle_ff <= csr_data[7:0];
            CSR_SLEW_STEP:  slew_step_ff  <= csr_data[7:0];
            CSR_PULSE_MIN:  pulse_min_ff  <= csr_data;
            CSR_PULSE_MAX:  pulse_max_ff  <= csr_data;
            default:        ;
         endcase
      end
   end

   // ---------------- state update for one item ----------------
   logic [8:0] up_sum;
   logic [7:0] down_diff;
   logic       done_now;

   always_comb begin
      current_pos_in = current_pos_ff;
      target_pos_in  = target_pos_ff;
      estop_prev_in  = estop_prev_ff;
      done_prev_in   = done_prev_ff;
      relay_state_in = relay_state_ff;
      duty_angle_in  = current_pos_ff;
      f1_in          = '0;
      up_sum         = {1'b0, current_pos_ff} + {1'b0, slew_step_ff};
      down_diff      = (current_pos_ff > slew_step_ff) ? (current_pos_ff - slew_step_ff) : 8'd0;
      done_now       = 1'b0;

      case (kind_in)
         KIND_TICK: begin
            f1_in.estop_pressed  = estop_in && !estop_prev_ff;
            f1_in.estop_released = !estop_in && estop_prev_ff;
            estop_prev_in        = estop_in;
            relay_state_in       = !estop_in && !fault_in;
            if (current_pos_ff < target_pos_ff) begin
               current_pos_in    = (up_sum > {1'b0, target_pos_ff}) ? target_pos_ff
                                                                    : up_sum[7:0];
               f1_in.duty_update = 1'b1;
            end else if (current_pos_ff > target_pos_ff) begin
               current_pos_in    = (down_diff < target_pos_ff) ? target_pos_ff : down_diff;
               f1_in.duty_update = 1'b1;
            end
            done_now = (current_pos_in == target_pos_ff);
            if (done_now && !done_prev_ff) begin
               f1_in.barrier_closed = (target_pos_ff == down_angle_ff);
               f1_in.barrier_open   = (target_pos_ff != down_angle_ff);
            end
            done_prev_in  = done_now;
            duty_angle_in = current_pos_in;
         end
         KIND_REQUEST: begin
            target_pos_in = angle_in;
            done_prev_in  = 1'b0;
         end
         KIND_FORCE: begin
            relay_state_in    = 1'b0;
            target_pos_in     = down_angle_ff;
            current_pos_in    = down_angle_ff;
            duty_angle_in     = down_angle_ff;
            f1_in.duty_update = 1'b1;
         end
         default: ;
      endcase

      f1_in.relay_on       = relay_state_in;
      f1_in.position       = current_pos_in;
      f1_in.target_reached = (current_pos_in == target_pos_in);
      f1_in.estop_held     = estop_prev_in;
      if (duty_angle_in > ANGLE_LIMIT) begin
         duty_angle_in = ANGLE_LIMIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         current_pos_ff <= UP_ANGLE_RESET;
         target_pos_ff  <= UP_ANGLE_RESET;
         estop_prev_ff  <= 1'b0;
         done_prev_ff   <= 1'b1;
         relay_state_ff <= 1'b0;
      end else if (accept) begin
         current_pos_ff <= current_pos_in;
         target_pos_ff  <= target_pos_in;
         estop_prev_ff  <= estop_prev_in;
         done_prev_ff   <= done_prev_in;
         relay_state_ff <= relay_state_in;
      end
   end

   // ---------------- duty map pipeline ----------------
   logic signed [16:0] span;
   logic signed [25:0] prod_in;
   logic [25:0]        mag;
   logic [44:0]        recip_prod;
   logic signed [17:0] offset_sum;
   logic signed [DUTY_BITS+17:0] duty_wide;
   logic signed [DUTY_BITS+17:0] duty_top_wide;
   logic [DUTY_BITS-1:0]         duty_new;

   assign span    = $signed({1'b0, pulse_max_ff}) - $signed({1'b0, pulse_min_ff});
   assign prod_in = span * $signed({1'b0, duty_angle_ff});
   assign mag     = prod_ff[25] ? 26'(-prod_ff) : 26'(prod_ff);
   assign recip_prod = {23'd0, mag_q4_ff} * {22'd0, RECIP_45};

   assign offset_sum    = neg4_ff ? ($signed({2'b00, pulse_min_ff}) - $signed({2'b00, quot_ff}))
                                  : ($signed({2'b00, pulse_min_ff}) + $signed({2'b00, quot_ff}));
   assign duty_wide     = {{DUTY_BITS{offset_sum[17]}}, offset_sum};
   assign duty_top_wide = {{18{1'b0}}, {DUTY_BITS{1'b1}}};

   always_comb begin
      if (duty_wide < 0) begin
         duty_new = '0;
      end else if (duty_wide > duty_top_wide) begin
         duty_new = {DUTY_BITS{1'b1}};
      end else begin
         duty_new = duty_wide[DUTY_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         v4_ff    <= 1'b0;
         out_v_ff <= 1'b0;
         duty_ff  <= DUTY_BITS'(DUTY_RESET);
      end else begin
         if (rdy1) v1_ff <= accept;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
         if (move_out) begin
            out_v_ff <= v4_ff;
            if (v4_ff && f4_ff.duty_update) begin
               duty_ff <= duty_new;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         f1_ff         <= f1_in;
         duty_angle_ff <= duty_angle_in;
      end
      if (v1_ff && rdy2) begin
         f2_ff   <= f1_ff;
         prod_ff <= prod_in;
      end
      if (v2_ff && rdy3) begin
         f3_ff     <= f2_ff;
         mag_q4_ff <= mag[23:2];
         neg3_ff   <= prod_ff[25];
      end
      if (v3_ff && rdy4) begin
         f4_ff   <= f3_ff;
         quot_ff <= recip_prod[RECIP_SHIFT+15:RECIP_SHIFT];
         neg4_ff <= neg3_ff;
      end
      if (v4_ff && move_out) begin
         out_f_ff <= f4_ff;
      end
   end

   // ---------------- result ----------------
   logic [DUTY_BITS+15:0] duty_ext;
   assign duty_ext = {16'd0, duty_ff};

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {1'b0,
                        out_f_ff.barrier_open,
                        out_f_ff.barrier_closed,
                        out_f_ff.estop_released,
                        out_f_ff.estop_pressed,
                        out_f_ff.estop_held,
                        out_f_ff.target_reached,
                        out_f_ff.position,
                        duty_ext[15:0],
                        out_f_ff.relay_on};

endmodule

`default_nettype wire

// File: tb/sv/servo_interlock_checker.sv
module servo_interlock_checker
   import bssi_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,
   output int          mismatch_count,
   output int          pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic        relay_on;
      logic [15:0] duty;
      logic [7:0]  position;
      logic        reached;
      logic        estop_held;
      logic        pressed;
      logic        released;
      logic        closed;
      logic        opened;
   } servo_result_type;

   logic [7:0]       down_reg;
   logic [7:0]       step_reg;
   logic [15:0]      pulse_lo;
   logic [15:0]      pulse_hi;
   int unsigned      cur_angle;
   int unsigned      tgt_angle;
   bit               estop_seen;
   bit               arrived_prev;
   bit               relay_state;
   logic [15:0]      duty_level;
   servo_result_type expected_q[$];
   int               result_index;

   initial begin
      mismatch_count = 0;
      pending_count  = 0;
      result_index   = 0;
   end

   // linear angle-to-duty map, angle clamped at full scale, saturated to the duty width
   function automatic logic [15:0] duty_for(int unsigned angle);
      longint span;
      longint level;
      longint ceiling;
      if (angle > ANGLE_LIMIT) angle = ANGLE_LIMIT;
      span    = longint'(pulse_hi) - longint'(pulse_lo);
      level   = longint'(pulse_lo) + (span * longint'(angle)) / longint'(ANGLE_LIMIT);
      ceiling = (longint'(1) << DUTY_BITS) - 1;
      if (level < 0) level = 0;
      if (level > ceiling) level = ceiling;
      return level[15:0];
   endfunction

   function automatic servo_result_type apply_item(kind_type kind, logic [7:0] angle,
                                                   logic estop, logic fault);
      servo_result_type r;
      int unsigned      nxt;
      bit               now_there;
      r = '0;
      case (kind)
         KIND_TICK: begin
            r.pressed   = estop && !estop_seen;
            r.released  = !estop && estop_seen;
            estop_seen  = estop;
            relay_state = !estop && !fault;
            if (cur_angle < tgt_angle) begin
               nxt        = cur_angle + step_reg;
               cur_angle  = (nxt > tgt_angle) ? tgt_angle : nxt;
               duty_level = duty_for(cur_angle);
            end else if (cur_angle > tgt_angle) begin
               nxt        = (cur_angle > step_reg) ? cur_angle - step_reg : 0;
               cur_angle  = (nxt < tgt_angle) ? tgt_angle : nxt;
               duty_level = duty_for(cur_angle);
            end
            now_there = (cur_angle == tgt_angle);
            // events fire only on the arrival edge
            if (now_there && !arrived_prev) begin
               if (tgt_angle == down_reg) r.closed = 1'b1;
               else r.opened = 1'b1;
            end
            arrived_prev = now_there;
         end
         KIND_REQUEST: begin
            tgt_angle    = angle;
            arrived_prev = 1'b0;
         end
         KIND_FORCE: begin
            relay_state = 1'b0;
            tgt_angle   = down_reg;
            cur_angle   = down_reg;
            duty_level  = duty_for(down_reg);
         end
         default: ;
      endcase
      r.relay_on   = relay_state;
      r.duty       = duty_level;
      r.position   = 8'(cur_angle);
      r.reached    = (cur_angle == tgt_angle);
      r.estop_held = estop_seen;
      return r;
   endfunction

   task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
      mismatch_count++;
      $display("%0t ns result %0d: %s got 0x%0h, expected 0x%0h",
               $time, result_index, what, got, want);
   endtask

   task automatic check_result(servo_result_type got, servo_result_type want);
      if (got.relay_on != want.relay_on) report_mismatch("relay_on", got.relay_on, want.relay_on);
      if (got.duty != want.duty) report_mismatch("servo_duty", got.duty, want.duty);
      if (got.position != want.position) report_mismatch("position", got.position, want.position);
      if (got.reached != want.reached) report_mismatch("target_reached", got.reached, want.reached);
      if (got.estop_held != want.estop_held)
         report_mismatch("estop_held", got.estop_held, want.estop_held);
      if (got.pressed != want.pressed) report_mismatch("estop_pressed", got.pressed, want.pressed);
      if (got.released != want.released)
         report_mismatch("estop_released", got.released, want.released);
      if (got.closed != want.closed) report_mismatch("barrier_closed", got.closed, want.closed);
      if (got.opened != want.opened) report_mismatch("barrier_open", got.opened, want.opened);
   endtask

   always @(posedge clock) begin
      servo_result_type got;
      if (reset) begin
         down_reg     = DOWN_ANGLE_RESET;
         step_reg     = SLEW_STEP_RESET;
         pulse_lo     = PULSE_MIN_RESET;
         pulse_hi     = PULSE_MAX_RESET;
         cur_angle    = UP_ANGLE_RESET;
         tgt_angle    = UP_ANGLE_RESET;
         estop_seen   = 1'b0;
         arrived_prev = 1'b1;
         relay_state  = 1'b0;
         duty_level   = duty_for(UP_ANGLE_RESET);
         expected_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_UP_ANGLE:   ;  // ignored, moves nothing
               CSR_DOWN_ANGLE: down_reg = csr_data[7:0];
               CSR_SLEW_STEP:  step_reg = csr_data[7:0];
               CSR_PULSE_MIN:  pulse_lo = csr_data;
               CSR_PULSE_MAX:  pulse_hi = csr_data;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            expected_q.push_back(apply_item(kind_type'(req_tuser), req_tdata[7:0],
                                            req_tdata[8], req_tdata[9]));
         if (rsp_tvalid && rsp_tready) begin
            got.relay_on   = rsp_tdata[0];
            got.duty       = rsp_tdata[16:1];
            got.position   = rsp_tdata[24:17];
            got.reached    = rsp_tdata[25];
            got.estop_held = rsp_tdata[26];
            got.pressed    = rsp_tdata[27];
            got.released   = rsp_tdata[28];
            got.closed     = rsp_tdata[29];
            got.opened     = rsp_tdata[30];
            if (expected_q.size() == 0) report_mismatch("unexpected result", rsp_tdata, 0);
            else check_result(got, expected_q.pop_front());
            result_index++;
         end
      end
      pending_count = expected_q.size();
   end

endmodule

// File: tb/sv/barrier_servo_slew_interlock_unit_tb.sv
module barrier_servo_slew_interlock_unit_tb
   import bssi_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam int QUIET_LIMIT = 2000;
   localparam int PHASES = 9;
   localparam int ITEMS_PER_PHASE = 150;

   logic        clock;
   logic        reset;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [15:0] csr_data;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   int          errors;
   int          pending;
   int          items_sent;
   int          quiet_cycles;
   bit          allow_gaps = 1'b1;
   bit          long_hold = 1'b0;
   bit          estop_level = 1'b0;

   barrier_servo_slew_interlock_unit uut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   servo_interlock_checker servo_checker (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .mismatch_count (errors),
      .pending_count  (pending)
   );

   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // stall when there is no transfer anywhere for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("barrier_servo_slew_interlock_unit_tb: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // receiver: short random back-pressure bursts, plus one long hold on request
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_tready = 1'b0;
            repeat (48) @(negedge clock);
            long_hold = 1'b0;
         end else if (allow_gaps && $urandom_range(0, 5) == 0) begin
            rsp_tready = 1'b0;
            repeat ($urandom_range(0, 2)) @(negedge clock);
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   // entered and left at a falling edge
   task automatic send_item(logic [1:0] kind, logic [7:0] angle, logic estop, logic fault);
      if (allow_gaps && $urandom_range(0, 7) == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = kind;
      req_tdata  = {6'd0, fault, estop, angle};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      if (kind != KIND_UNUSED) items_sent++;
   endtask

   task automatic tick(logic estop, logic fault);
      send_item(KIND_TICK, 8'($urandom), estop, fault);
   endtask

   task automatic write_reg(csr_index_type idx, logic [15:0] value);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic wait_drained();
      req_tvalid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic load_settings(logic [7:0] up, logic [7:0] down, logic [7:0] step,
                                logic [15:0] lo, logic [15:0] hi);
      wait_drained();
      write_reg(CSR_UP_ANGLE, {8'd0, up});
      write_reg(CSR_DOWN_ANGLE, {8'd0, down});
      write_reg(CSR_SLEW_STEP, {8'd0, step});
      write_reg(CSR_PULSE_MIN, lo);
      write_reg(CSR_PULSE_MAX, hi);
   endtask

   function automatic logic [7:0] pick_target();
      case ($urandom_range(0, 5))
         0:       return 8'd0;
         1:       return 8'($urandom_range(0, 255));
         2:       return 8'($urandom_range(181, 255));
         default: return 8'($urandom_range(0, 180));
      endcase
   endfunction

   // mostly request-then-ticks sequences, with some stray items mixed in
   task automatic run_motion(int count);
      int stop_at;
      int n_ticks;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         if ($urandom_range(0, 99) < 8) begin
            send_item(2'($urandom_range(0, 3)), 8'($urandom), 1'($urandom), 1'($urandom));
         end else begin
            send_item(KIND_REQUEST, pick_target(), 1'($urandom), 1'($urandom));
            n_ticks = $urandom_range(1, 40);
            if (n_ticks > stop_at - items_sent) n_ticks = stop_at - items_sent;
            for (int i = 0; i < n_ticks; i++) begin
               if ($urandom_range(0, 9) == 0) estop_level = !estop_level;
               if ($urandom_range(0, 49) == 0) begin
                  send_item(KIND_FORCE, 8'($urandom), 1'($urandom), 1'($urandom));
               end else begin
                  tick(estop_level, $urandom_range(0, 5) == 0);
               end
            end
         end
      end
   endtask

   initial begin
      reset      = 1'b1;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      items_sent = 0;
      repeat (12) @(negedge clock);
      reset = 1'b0;

      // reset settings: e-stop edges, fault, arrival with no move, unused kind, force safe
      tick(1'b0, 1'b0);
      tick(1'b1, 1'b0);
      tick(1'b1, 1'b1);
      tick(1'b0, 1'b1);
      send_item(KIND_REQUEST, 8'd90, 1'b0, 1'b0);
      tick(1'b0, 1'b0);
      send_item(KIND_UNUSED, 8'hFF, 1'b1, 1'b1);
      send_item(KIND_FORCE, 8'd0, 1'b0, 1'b0);
      tick(1'b0, 1'b0);

      // full-scale step and pulse range: overshoot past 180, clamp at target, closed event
      load_settings(8'd90, 8'd0, 8'd180, 16'd0, 16'hFFFF);
      send_item(KIND_REQUEST, 8'd255, 1'b0, 1'b0);
      tick(1'b0, 1'b0);
      tick(1'b0, 1'b0);
      send_item(KIND_REQUEST, 8'd0, 1'b0, 1'b0);
      tick(1'b0, 1'b0);
      tick(1'b0, 1'b0);
      send_item(KIND_REQUEST, 8'd180, 1'b1, 1'b1);
      tick(1'b0, 1'b0);

      // zero step and reversed pulse range, down angle at the top end
      load_settings(8'd180, 8'd180, 8'd0, 16'hFFFF, 16'd0);
      send_item(KIND_REQUEST, 8'd100, 1'b0, 1'b0);
      tick(1'b0, 1'b0);
      send_item(KIND_FORCE, 8'd0, 1'b0, 1'b0);
      tick(1'b0, 1'b0);
      send_item(KIND_REQUEST, 8'd0, 1'b0, 1'b0);
      tick(1'b0, 1'b0);

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: load_settings(8'd90, 8'd0, 8'd2, 16'd1638, 16'd7864);
            1: load_settings(8'd180, 8'd180, 8'd1, 16'd0, 16'hFFFF);
            2: load_settings(8'd0, 8'd0, 8'd180, 16'hFFFF, 16'd0);
            4: load_settings(8'd45, 8'd90, 8'd7, 16'd20000, 16'd3000);
            default: load_settings(8'($urandom_range(0, 180)), 8'($urandom_range(0, 180)),
                                   ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 180))
                                                               : 8'($urandom_range(1, 12)),
                                   16'($urandom), 16'($urandom));
         endcase
         allow_gaps = (p < PHASES - 1);
         if (p == 3 || p == 6) long_hold = 1'b1;
         run_motion(ITEMS_PER_PHASE / 2);
         wait_drained();
         run_motion(ITEMS_PER_PHASE / 2);
      end

      req_tvalid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (errors == 0 && pending == 0) begin
         $display("barrier_servo_slew_interlock_unit_tb: clean");
      end else begin
         $display("barrier_servo_slew_interlock_unit_tb: errors");
      end
      $finish;
   end

endmodule
